### rtl/h2r_pkg.sv
// shared widths, constants and beat types for the hsl to rgb converter
package h2r_pkg;

  localparam int FracBits = 12;
  localparam int One      = 1 << FracBits;
  localparam int Third    = One / 3;

  localparam int InW   = FracBits + 1;
  localparam int SqW   = 2 * FracBits + 1;
  localparam int GainW = FracBits + 1;
  localparam int CubeW = 3 * FracBits + 1;
  localparam int Lanes = 3;

  typedef logic [InW-1:0]   in_t;
  typedef logic [SqW-1:0]   sq_t;
  typedef logic [GainW-1:0] gain_t;
  typedef logic [CubeW-1:0] cube_t;

  typedef struct packed {
    sq_t                  m2;
    in_t                  l;
    logic [Lanes-1:0][InW-1:0] vh;
  } front_t;

  typedef struct packed {
    sq_t                     m1;
    sq_t                     d;
    logic [Lanes-1:0][GainW-1:0] g;
  } lane_t;

endpackage

### rtl/h2r_front.sv
// input clamp, m2 product and shifted hues (two stages)
module h2r_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  h2r_pkg::in_t    hue_i,
  input  h2r_pkg::in_t    sat_i,
  input  h2r_pkg::in_t    lgt_i,
  output logic            vld_o,
  output h2r_pkg::front_t front_o
);
  import h2r_pkg::*;

  logic   vld0_q, vld1_q;
  in_t    h_q, s_q, l_q;
  in_t    h_d, s_d, l_d;
  sq_t    ls, lsh, ssh, m2_d;
  logic [InW:0] hp, hm;
  front_t front_d, front_q;

  // clamp to one
  assign h_d = (hue_i > InW'(One)) ? InW'(One) : hue_i;
  assign s_d = (sat_i > InW'(One)) ? InW'(One) : sat_i;
  assign l_d = (lgt_i > InW'(One)) ? InW'(One) : lgt_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
    end else begin
      vld0_q <= vld_i;
      vld1_q <= vld0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q     <= h_d;
    s_q     <= s_d;
    l_q     <= l_d;
    front_q <= front_d;
  end

  assign ls  = SqW'(s_q) * SqW'(l_q);
  assign lsh = SqW'(l_q) << FracBits;
  assign ssh = SqW'(s_q) << FracBits;

  always_comb begin
    if (l_q < InW'(One / 2)) begin
      m2_d = lsh + ls;
    end else begin
      m2_d = lsh + (ssh - ls);
    end
  end

  // hue plus and minus a third, wrapped into [0, one]
  always_comb begin
    hp = (InW+1)'(h_q) + (InW+1)'(Third);
    if (hp > (InW+1)'(One)) begin
      hp = hp - (InW+1)'(One);
    end
    if (h_q < InW'(Third)) begin
      hm = (InW+1)'(h_q) + (InW+1)'(One - Third);
    end else begin
      hm = (InW+1)'(h_q) - (InW+1)'(Third);
    end
  end

  always_comb begin
    front_d.m2    = m2_d;
    front_d.l     = l_q;
    front_d.vh[0] = hp[InW-1:0];
    front_d.vh[1] = h_q;
    front_d.vh[2] = hm[InW-1:0];
  end

  assign vld_o   = vld1_q;
  assign front_o = front_q;

endmodule

### rtl/h2r_gain.sv
// m1, ramp span and per-channel ramp gain (one stage)
module h2r_gain (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  h2r_pkg::front_t front_i,
  output logic            vld_o,
  output h2r_pkg::lane_t  lane_o
);
  import h2r_pkg::*;

  localparam int W = FracBits + 4;

  logic         vld_q;
  logic [SqW:0] m1_w;
  lane_t        lane_d, lane_q;

  function automatic gain_t ramp_gain(input in_t vh);
    logic [W-1:0] v2, v3, v6;
    gain_t        g;
    v2 = W'(vh) << 1;
    v3 = W'(vh) + v2;
    v6 = (W'(vh) << 2) + v2;
    if (v6 < W'(One)) begin
      g = GainW'(v6);
    end else if (v2 < W'(One)) begin
      g = GainW'(One);
    end else if (v3 < W'(2 * One)) begin
      g = GainW'(W'(4 * One) - v6);
    end else begin
      g = '0;
    end
    return g;
  endfunction

  assign m1_w = ((SqW+1)'(front_i.l) << (FracBits + 1)) - (SqW+1)'(front_i.m2);

  always_comb begin
    lane_d.m1 = m1_w[SqW-1:0];
    lane_d.d  = front_i.m2 - m1_w[SqW-1:0];
    for (int i = 0; i < Lanes; i++) begin
      lane_d.g[i] = ramp_gain(front_i.vh[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign vld_o  = vld_q;
  assign lane_o = lane_q;

endmodule

### rtl/h2r_chan.sv
// three channel lanes: ramp product, offset add, scale to byte (three stages)
module h2r_chan (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           vld_i,
  input  h2r_pkg::lane_t                 lane_i,
  output logic                           vld_o,
  output logic [h2r_pkg::Lanes-1:0][7:0] byte_o
);
  import h2r_pkg::*;

  localparam int TW = CubeW + 8;

  logic [2:0]               vld_q;
  sq_t                      m1_q;
  cube_t [Lanes-1:0]        p_q, c_q;
  cube_t [Lanes-1:0]        c_d;
  logic [Lanes-1:0][7:0]    byte_d, byte_q;
  logic [TW-1:0]            t;
  logic [TW-3*FracBits-1:0] v;

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      c_d[i] = (CubeW'(m1_q) << FracBits) + p_q[i];
    end
  end

  // scale by 255, truncate, saturate
  always_comb begin
    t = '0;
    v = '0;
    for (int i = 0; i < Lanes; i++) begin
      t = (TW'(c_q[i]) << 8) - TW'(c_q[i]);
      v = t[TW-1:3*FracBits];
      byte_d[i] = (v > (TW-3*FracBits)'(255)) ? 8'hff : v[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q <= lane_i.m1;
    for (int i = 0; i < Lanes; i++) begin
      p_q[i] <= CubeW'(lane_i.d) * CubeW'(lane_i.g[i]);
    end
    c_q    <= c_d;
    byte_q <= byte_d;
  end

  assign vld_o  = vld_q[2];
  assign byte_o = byte_q;

endmodule

### rtl/hsl_to_rgb_converter.sv
// top level of the hsl to rgb converter: front, gain and channel stages
// throughput: one beat per cycle, set by the six-stage pipeline with no stall path
// busy stays low; the receiver cannot stall, so results leave on their strobe
// reset clears every valid bit; payload registers are not reset
module hsl_to_rgb_converter (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  h2r_pkg::in_t hue_i,
  input  h2r_pkg::in_t saturation_i,
  input  h2r_pkg::in_t lightness_i,
  output logic         valid_o,
  output logic [7:0]   red_o,
  output logic [7:0]   green_o,
  output logic [7:0]   blue_o
);
  import h2r_pkg::*;

  logic                  front_vld, gain_vld;
  front_t                front;
  lane_t                 lane;
  logic [Lanes-1:0][7:0] bytes;

  assign busy = 1'b0;

  h2r_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (start & ~busy),
    .hue_i   (hue_i),
    .sat_i   (saturation_i),
    .lgt_i   (lightness_i),
    .vld_o   (front_vld),
    .front_o (front)
  );

  h2r_gain u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (front_vld),
    .front_i (front),
    .vld_o   (gain_vld),
    .lane_o  (lane)
  );

  h2r_chan u_chan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (gain_vld),
    .lane_i (lane),
    .vld_o  (valid_o),
    .byte_o (bytes)
  );

  assign red_o   = bytes[0];
  assign green_o = bytes[1];
  assign blue_o  = bytes[2];

endmodule

### tb/tb_hsl_to_rgb_converter.sv
// self-checking testbench for the hsl to rgb converter with a built-in color predictor
`timescale 1ns / 1ps

module tb_hsl_to_rgb_converter;
  import h2r_pkg::*;

  localparam int HalfPeriod = 6;
  localparam int ResetCycles = 11;
  localparam int DrainCycles = 10;
  localparam int QuietLimit = 500;
  localparam int RandomItems = 1000;
  localparam int IdlePct = 11;

  typedef struct {
    in_t hue;
    in_t sat;
    in_t light;
  } hsl_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t hue_i = '0;
  in_t saturation_i = '0;
  in_t lightness_i = '0;
  logic valid_o;
  logic [7:0] red_o;
  logic [7:0] green_o;
  logic [7:0] blue_o;

  hsl_t pending_hsl_q[$];
  rgb_t expected_rgb_q[$];
  int mismatch_cnt = 0;
  int accepted_cnt = 0;
  int quiet_cycles = 0;

  hsl_to_rgb_converter dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .hue_i(hue_i),
    .saturation_i(saturation_i),
    .lightness_i(lightness_i),
    .valid_o(valid_o),
    .red_o(red_o),
    .green_o(green_o),
    .blue_o(blue_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  function automatic longint clamp_unit(in_t v);
    if (v > One) begin
      return One;
    end
    return longint'(v);
  endfunction

  // lo, hi at scale one squared, vh at scale one, result at scale one cubed
  function automatic longint hue_ramp(longint lo, longint hi, longint vh);
    longint w;
    w = vh;
    if (w < 0) begin
      w = w + One;
    end
    if (w > One) begin
      w = w - One;
    end
    if (6 * w < One) begin
      return lo * One + (hi - lo) * 6 * w;
    end
    if (2 * w < One) begin
      return hi * One;
    end
    if (3 * w < 2 * One) begin
      return lo * One + (hi - lo) * (4 * One - 6 * w);
    end
    return lo * One;
  endfunction

  function automatic logic [7:0] to_channel(longint c);
    longint v;
    v = (c < 0) ? 0 : c;
    v = (v * 255) >> (3 * FracBits);
    if (v > 255) begin
      v = 255;
    end
    return v[7:0];
  endfunction

  function automatic rgb_t hsl_to_rgb(hsl_t px);
    longint h;
    longint s;
    longint l;
    longint m1;
    longint m2;
    longint grey;
    rgb_t c;
    h = clamp_unit(px.hue);
    s = clamp_unit(px.sat);
    l = clamp_unit(px.light);
    if (s == 0) begin
      grey = (l * 255) >> FracBits;
      if (grey > 255) begin
        grey = 255;
      end
      c.red = grey[7:0];
      c.green = grey[7:0];
      c.blue = grey[7:0];
      return c;
    end
    if (2 * l < One) begin
      m2 = l * (One + s);
    end else begin
      m2 = (l + s) * One - s * l;
    end
    m1 = 2 * l * One - m2;
    c.red = to_channel(hue_ramp(m1, m2, h + Third));
    c.green = to_channel(hue_ramp(m1, m2, h));
    c.blue = to_channel(hue_ramp(m1, m2, h - Third));
    return c;
  endfunction

  task automatic add_color(int h, int s, int l);
    hsl_t px;
    px.hue = in_t'(h);
    px.sat = in_t'(s);
    px.light = in_t'(l);
    pending_hsl_q.push_back(px);
  endtask

  task automatic report_mismatch(string msg);
    mismatch_cnt++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // mostly in range, with extremes, ramp edges and over-range codes mixed in
  function automatic in_t rand_unit();
    int edges[8] = '{682, 683, 1365, 2047, 2048, 2730, 2731, 4095};
    case ($urandom_range(9))
      0: return '0;
      1: return in_t'(One);
      2: return in_t'($urandom_range(8191));
      3: return in_t'(edges[$urandom_range(7)] + $urandom_range(2) - 1);
      default: return in_t'($urandom_range(One));
    endcase
  endfunction

  // no idling while the middle of the run goes through
  function automatic logic calm_stretch();
    return accepted_cnt >= 400 && accepted_cnt < 600;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni && pending_hsl_q.size() > 0 &&
        (calm_stretch() || $urandom_range(99) >= IdlePct)) begin
      start <= 1'b1;
      hue_i <= pending_hsl_q[0].hue;
      saturation_i <= pending_hsl_q[0].sat;
      lightness_i <= pending_hsl_q[0].light;
    end else begin
      start <= 1'b0;
      hue_i <= in_t'($urandom);
      saturation_i <= in_t'($urandom);
      lightness_i <= in_t'($urandom);
    end
  end

  always @(posedge clk_i) begin
    hsl_t px;
    rgb_t got;
    rgb_t want;
    if (rst_ni && start && !busy) begin
      px.hue = hue_i;
      px.sat = saturation_i;
      px.light = lightness_i;
      expected_rgb_q.push_back(hsl_to_rgb(px));
      void'(pending_hsl_q.pop_front());
      accepted_cnt++;
    end
    if (rst_ni && valid_o) begin
      got = {red_o, green_o, blue_o};
      if (expected_rgb_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat rgb %0d %0d %0d", red_o, green_o, blue_o));
      end else begin
        want = expected_rgb_q.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
          report_mismatch($sformatf("rgb got %0d %0d %0d want %0d %0d %0d",
                                    got.red, got.green, got.blue,
                                    want.red, want.green, want.blue));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((rst_ni && start && !busy) || (rst_ni && valid_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("tb_hsl_to_rgb_converter NOT OK");
      $finish;
    end
  end

  initial begin
    hsl_t px;
    // extremes, grey, out-of-range clamping, lightness midpoint, ramp edges, hue wrap
    add_color(0, 0, 0);
    add_color(One, One, One);
    add_color(0, 0, 2048);
    add_color(1234, 0, One);
    add_color(8191, 8191, 8191);
    add_color(4097, 4097, 4097);
    add_color(8191, 0, 8191);
    add_color(0, One, 2047);
    add_color(0, One, 2048);
    add_color(One, One, 2048);
    add_color(682, 3000, 1500);
    add_color(683, 3000, 1500);
    add_color(2047, 3000, 2500);
    add_color(2048, 3000, 2500);
    add_color(2730, 2000, 1000);
    add_color(2731, 2000, 3000);
    add_color(Third, One, 2048);
    add_color(0, 1, 2048);
    add_color(One - 1, One, 1);
    add_color(2731, One, 2048);
    add_color(6000, 2048, 1024);
    add_color(1365, 5000, 3000);
    for (int i = 0; i < RandomItems; i++) begin
      px.hue = rand_unit();
      px.sat = ($urandom_range(9) == 0) ? in_t'(0) : rand_unit();
      px.light = rand_unit();
      pending_hsl_q.push_back(px);
    end
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (pending_hsl_q.size() != 0 || expected_rgb_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb_hsl_to_rgb_converter OK");
    end else begin
      $display("tb_hsl_to_rgb_converter NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
rtl/h2r_pkg.sv
rtl/h2r_front.sv
rtl/h2r_gain.sv
rtl/h2r_chan.sv
rtl/hsl_to_rgb_converter.sv
tb/tb_hsl_to_rgb_converter.sv
